// ===== rtl/core/fdt_sbs_pkg.sv =====
package fdt_sbs_pkg;

  localparam int MAX_DEPTH = 255;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

  localparam int WORD_W  = 32;
  localparam int DWL_W   = 30;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // structure block tokens
  localparam logic [WORD_W-1:0] TOK_BEGIN   = 32'd1;
  localparam logic [WORD_W-1:0] TOK_ENDNODE = 32'd2;
  localparam logic [WORD_W-1:0] TOK_PROP    = 32'd3;
  localparam logic [WORD_W-1:0] TOK_NOP     = 32'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WALK_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRUCT_END = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SIZE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_PAST  = 2'd2,
    ST_DEPTH = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_TOKEN = 6'b000010,
    PH_NAME  = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_NOFF  = 6'b010000,
    PH_DATA  = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [DEPTH_W-1:0]  depth;
    logic [WORD_W-1:0]   cur;
    logic [DWL_W-1:0]    dwl;
    logic                ftp;
  } walk_state_t;

  typedef struct packed {
    logic               walk_mode;
    logic [WORD_W-1:0]  struct_end;
    logic [WORD_W-1:0]  total_size;
  } cfg_t;

  typedef struct packed {
    logic               emit;
    logic [WORD_W-1:0]  end_offset;
    status_t            status;
  } result_t;

endpackage

// ===== rtl/core/fdt_sbs_step.sv =====
module fdt_sbs_step (
  input  fdt_sbs_pkg::walk_state_t         cur_state,
  input  fdt_sbs_pkg::cfg_t                cfg,
  input  logic [fdt_sbs_pkg::WORD_W-1:0]   word,
  input  logic                             first_word,
  input  logic [fdt_sbs_pkg::WORD_W-1:0]   start_offset,
  output fdt_sbs_pkg::walk_state_t         state_next,
  output fdt_sbs_pkg::result_t             res
);
  import fdt_sbs_pkg::*;

  always_comb begin
    walk_state_t        b;
    walk_state_t        n;
    logic [WORD_W-1:0]  off4;
    logic               past;
    logic               at_end;
    logic               at_end4;
    logic [3:0]         zb;
    logic [1:0]         lim;
    logic               name_past;
    logic               fin;
    logic               fin_prop;
    logic               header;
    logic [DWL_W-1:0]   dwl_dec;
    logic [WORD_W:0]    len_up;

    b = cur_state;
    if (first_word) begin
      b.cur   = {start_offset[WORD_W-1:2], 2'b00};
      b.depth = '0;
      b.dwl   = '0;
      b.ftp   = 1'b1;
      b.phase = PH_TOKEN;
    end
    n = b;
    res = '{emit: 1'b0, end_offset: '0, status: ST_OK};
    fin = 1'b0;
    fin_prop = 1'b0;
    header = cfg.walk_mode;

    off4    = b.cur + WORD_W'(4);
    past    = ({1'b0, b.cur} + (WORD_W+1)'(4)) > {1'b0, cfg.total_size};
    at_end  = b.cur >= cfg.struct_end;
    at_end4 = off4 >= cfg.struct_end;

    // zero byte scan, first byte in the top bits
    for (int j = 0; j < 4; j++) begin
      zb[j] = (word[31-8*j -: 8] == 8'h00);
    end
    lim = zb[0] ? 2'd0 : zb[1] ? 2'd1 : zb[2] ? 2'd2 : 2'd3;
    name_past = ({1'b0, b.cur} + {{(WORD_W-1){1'b0}}, lim}) >= {1'b0, cfg.total_size};

    len_up  = {1'b0, word} + (WORD_W+1)'(3);
    dwl_dec = (b.dwl != '0) ? b.dwl - DWL_W'(1) : b.dwl;

    case (b.phase)
      PH_TOKEN: begin
        if (past) begin
          res = '{emit: 1'b1, end_offset: '0, status: ST_PAST};
        end else if (header && b.ftp) begin
          if (word != TOK_BEGIN) begin
            res = '{emit: 1'b1, end_offset: '0, status: ST_BAD};
          end else begin
            n.ftp   = 1'b0;
            n.cur   = off4;
            n.phase = PH_NAME;
          end
        end else if (header || (!b.ftp && b.depth == '0)) begin
          // only properties may follow: anything else ends the run unconsumed
          if (word != TOK_PROP) begin
            res = '{emit: 1'b1, end_offset: b.cur, status: ST_OK};
          end else begin
            n.cur   = off4;
            n.phase = PH_LEN;
          end
        end else if (b.ftp && word == TOK_PROP && at_end) begin
          res = '{emit: 1'b1, end_offset: b.cur, status: ST_OK};
        end else begin
          n.ftp = 1'b0;
          case (word)
            TOK_BEGIN: begin
              if (b.depth >= DEPTH_W'(MAX_DEPTH)) begin
                res = '{emit: 1'b1, end_offset: '0, status: ST_DEPTH};
              end else begin
                n.depth = b.depth + DEPTH_W'(1);
                n.cur   = off4;
                n.phase = PH_NAME;
              end
            end
            TOK_ENDNODE: begin
              if (b.depth == '0) begin
                res = '{emit: 1'b1, end_offset: '0, status: ST_BAD};
              end else begin
                n.depth = b.depth - DEPTH_W'(1);
                n.cur   = off4;
                fin     = 1'b1;
              end
            end
            TOK_PROP: begin
              n.cur   = off4;
              n.phase = PH_LEN;
            end
            TOK_NOP: begin
              n.cur = off4;
              fin   = 1'b1;
            end
            default: begin
              res = '{emit: 1'b1, end_offset: '0, status: ST_BAD};
            end
          endcase
        end
      end
      PH_NAME: begin
        if (name_past) begin
          res = '{emit: 1'b1, end_offset: '0, status: ST_PAST};
        end else begin
          n.cur = off4;
          fin   = |zb;
        end
      end
      PH_LEN: begin
        if (past) begin
          res = '{emit: 1'b1, end_offset: '0, status: ST_PAST};
        end else begin
          n.dwl   = len_up[DWL_W+1:2];
          n.cur   = off4;
          n.phase = PH_NOFF;
        end
      end
      PH_NOFF: begin
        n.cur = off4;
        if (b.dwl == '0) begin
          fin      = 1'b1;
          fin_prop = 1'b1;
        end else begin
          n.phase = PH_DATA;
        end
      end
      PH_DATA: begin
        n.cur = off4;
        n.dwl = dwl_dec;
        if (dwl_dec == '0) begin
          fin      = 1'b1;
          fin_prop = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // token finished: n.cur is off4 on every path that sets fin
    if (fin) begin
      if ((!header && n.depth == '0 && !fin_prop) || at_end4) begin
        res = '{emit: 1'b1, end_offset: off4, status: ST_OK};
      end else begin
        n.phase = PH_TOKEN;
      end
    end

    if (res.emit) begin
      n.phase = PH_IDLE;
    end
    state_next = n;
  end

endmodule

// ===== rtl/core/fdt_struct_block_skipper.sv =====
// Channel   Dir  Width  Contents (lowest bit up)
// s_*       in   64+1   tdata: word[31:0], start_offset[63:32]; tuser: first_word
// m_*       out  32+2   tdata: end_offset[31:0]; tuser: status[1:0]
// cfg_*     in   1+2+32 write enable, register index, write data
//
// One beat per cycle, sustained while m_tready holds. A beat lands in the input
// register, the walk step logic works on it in the next cycle and a result, if
// any, goes to the output register. rst is synchronous and clears the walk
// state, the configuration registers and both valids. A stalled result holds
// the output register; the input register drains into it as soon as it frees,
// so input stalls only while both are full.
module fdt_struct_block_skipper (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [63:0]                        s_tdata,  // word, start_offset
  input  logic                               s_tuser,  // first_word
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [fdt_sbs_pkg::WORD_W-1:0]     m_tdata,  // end_offset
  output logic [1:0]                         m_tuser,  // status
  input  logic                               cfg_we,
  input  logic [fdt_sbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdt_sbs_pkg::CFG_W-1:0]      cfg_data
);
  import fdt_sbs_pkg::*;

  // configuration registers, read live by the step logic
  cfg_t cfg;

  // input register
  logic               in_valid;
  logic [WORD_W-1:0]  in_word;
  logic [WORD_W-1:0]  in_start;
  logic               in_first;

  walk_state_t walk;
  walk_state_t walk_next;
  result_t     res;
  logic        advance;

  // a held beat moves on when the output register has room
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{walk_mode: 1'b0, struct_end: '0, total_size: '0};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WALK_MODE:  cfg.walk_mode  <= cfg_data[0];
        CFG_STRUCT_END: cfg.struct_end <= cfg_data;
        CFG_TOTAL_SIZE: cfg.total_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word  <= s_tdata[31:0];
      in_start <= s_tdata[63:32];
      in_first <= s_tuser;
    end
  end

  fdt_sbs_step u_step (
    .cur_state    (walk),
    .cfg          (cfg),
    .word         (in_word),
    .first_word   (in_first),
    .start_offset (in_start),
    .state_next   (walk_next),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '{phase: PH_IDLE, depth: '0, cur: '0, dwl: '0, ftp: 1'b0};
    end else if (advance) begin
      walk <= walk_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      m_tdata <= res.end_offset;
      m_tuser <= res.status;
    end
  end

  // errors always report offset zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("error result with nonzero end offset");

  // good walks end on a word boundary
  a_ok_aligned: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_OK) |-> (m_tdata[1:0] == 2'b00))
    else $error("unaligned end offset");

  // a result closes the walk
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && res.emit) |=> (walk.phase == PH_IDLE))
    else $error("walk still active after result");

  a_depth_max: assert property (@(posedge clk) disable iff (rst)
    walk.depth <= DEPTH_W'(MAX_DEPTH))
    else $error("nest depth above limit");

endmodule
